/* design/msb_pkg.sv */
// Shared types and constants for the multi-stack bank.
// Holds the request and response beat layouts and the control/status bundles.
// No dependencies.
`default_nettype none

package msb_pkg;

    // Field widths fixed by the request and response layouts.
    localparam int INDEX_W    = 4;
    localparam int VALUE_W    = 32;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_INDEX_W = 1;

    // Request operation codes.
    localparam logic [1:0] KIND_PUSH = 2'd0;
    localparam logic [1:0] KIND_POP  = 2'd1;
    localparam logic [1:0] KIND_TOP  = 2'd2;

    // Response status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;
    localparam logic [1:0] STATUS_NO_STACK  = 2'd3;

    // Configuration register indexes and reset values.
    localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNT    = 1'b1;
    localparam logic [8:0] CAPACITY_RESET = 9'd256;
    localparam logic [4:0] COUNT_RESET    = 5'd16;

    // One request beat.
    typedef struct packed {
        logic [1:0]                kind;
        logic [INDEX_W-1:0]        stack_index;
        logic signed [VALUE_W-1:0] push_value;
    } req_t;

    // One response beat.
    typedef struct packed {
        logic [1:0]                status;
        logic signed [VALUE_W-1:0] result_value;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture_req;
        logic execute;
        logic capture_read;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_read;
    } stat_t;

endpackage

`default_nettype wire

/* design/multi_stack_bank.sv */
// Top level of the multi-stack bank: a bank of LIFO stacks in one RAM.
// Depends on msb_pkg, msb_ctrl and msb_datapath.
//
//   channel  direction  handshake               beat
//   req      in         req_valid / req_stall   msb_pkg::req_t
//   rsp      out        rsp_valid / rsp_stall   msb_pkg::rsp_t
//   cfg      in         cfg_write_en            cfg_index, cfg_data
//
// A push or a rejected request runs through the execute and deliver states
// between acceptances; a pop or top adds the fetch state for the registered
// read of the single-port stack RAM. The response register lets the next
// request be accepted while a response is still stalled; delivery waits
// only when that register is still full. Reset empties every stack at once
// through the per-stack fill counters; the RAM needs no clearing pass.
`default_nettype none

module multi_stack_bank #(
    parameter int NUM_STACKS  = 16,
    parameter int STACK_DEPTH = 256,
    parameter int DATA_WIDTH  = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_stall,
    input  wire msb_pkg::req_t                   req_data,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_stall,
    output msb_pkg::rsp_t                        rsp_data,
    input  wire logic                            cfg_write_en,
    input  wire logic [msb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [msb_pkg::CFG_DATA_W-1:0]  cfg_data
);

    msb_pkg::cmd_t  cmd;
    msb_pkg::stat_t stat;

    // Request sequencer.
    msb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Stack storage and result path.
    msb_datapath #(
        .NUM_STACKS  (NUM_STACKS),
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_data     (req_data),
        .rsp_data     (rsp_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

`default_nettype wire

/* design/msb_ram.sv */
// Generic single-port RAM with a registered read.
// One access per cycle: a write or a read at one address.
// No dependencies.
`default_nettype none

module msb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                                       clk,
    input  wire logic                                       en,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                           wdata,
    output logic [WIDTH-1:0]                                rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, or read into the output register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* design/msb_datapath.sv */
// Datapath of the multi-stack bank: configuration, fill counters, stack RAM
// and the result and response registers.
// Depends on msb_pkg and msb_ram.
`default_nettype none

module msb_datapath #(
    parameter int NUM_STACKS  = 16,
    parameter int STACK_DEPTH = 256,
    parameter int DATA_WIDTH  = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire msb_pkg::req_t                      req_data,
    output msb_pkg::rsp_t                           rsp_data,
    input  wire logic                               cfg_write_en,
    input  wire logic [msb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [msb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire msb_pkg::cmd_t                      cmd,
    output msb_pkg::stat_t                          stat
);

    // Only as many stacks as the request index can reach get storage.
    localparam int REACH       = 1 << msb_pkg::INDEX_W;
    localparam int USED_STACKS = (NUM_STACKS < REACH) ? NUM_STACKS : REACH;
    localparam int IDX_W       = (USED_STACKS > 1) ? $clog2(USED_STACKS) : 1;
    localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
    localparam int MEM_DEPTH   = USED_STACKS * STACK_DEPTH;
    localparam int ADDR_W      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CMP_W       = (FILL_W > msb_pkg::CFG_DATA_W) ? FILL_W
                                                                : msb_pkg::CFG_DATA_W;

    logic [8:0]               cap_reg;
    logic [4:0]               count_reg;
    msb_pkg::req_t            req_reg;
    logic [FILL_W-1:0]        fill_reg [USED_STACKS];
    logic [1:0]               res_status_reg;
    logic [msb_pkg::VALUE_W-1:0] res_value_reg;
    msb_pkg::rsp_t            rsp_reg;

    logic [IDX_W-1:0]         idx_sel;
    logic [FILL_W-1:0]        fill_sel;
    logic                     in_range;
    logic                     full;
    logic                     empty;
    logic [DATA_WIDTH-1:0]    push_word;
    logic signed [63:0]       push_wide;
    logic signed [63:0]       word_wide;
    logic signed [63:0]       read_wide;
    logic [ADDR_W-1:0]        base_addr;
    logic [ADDR_W-1:0]        push_addr;
    logic [ADDR_W-1:0]        top_addr;
    logic                     do_write;
    logic                     do_read;
    logic                     do_pop;
    logic [1:0]               dec_status;
    logic [DATA_WIDTH-1:0]    ram_rdata;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= msb_pkg::CAPACITY_RESET;
            count_reg <= msb_pkg::COUNT_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                msb_pkg::CFG_CAPACITY: cap_reg   <= cfg_data[8:0];
                msb_pkg::CFG_COUNT:    count_reg <= cfg_data[4:0];
            endcase
        end
    end

    // Lookup of the addressed stack.
    assign idx_sel  = req_reg.stack_index[IDX_W-1:0];
    assign fill_sel = fill_reg[idx_sel];
    assign in_range = ({1'b0, req_reg.stack_index} < count_reg) &&
                      ({1'b0, req_reg.stack_index} < 5'(USED_STACKS));
    assign full     = (CMP_W'(fill_sel) >= CMP_W'(cap_reg)) ||
                      (CMP_W'(fill_sel) >= CMP_W'(STACK_DEPTH));
    assign empty    = (fill_sel == '0);

    // Stored word and its sign-extended view.
    assign push_wide = 64'($signed(req_reg.push_value));
    assign push_word = push_wide[DATA_WIDTH-1:0];
    assign word_wide = 64'($signed(push_word));
    assign read_wide = 64'($signed(ram_rdata));

    // RAM addresses: stack base plus slot.
    assign base_addr = ADDR_W'(idx_sel) * ADDR_W'(STACK_DEPTH);
    assign push_addr = base_addr + ADDR_W'(fill_sel);
    assign top_addr  = base_addr + ADDR_W'(fill_sel - FILL_W'(1));

    // Request decode.
    always_comb
    begin
        dec_status = msb_pkg::STATUS_OK;
        do_write   = 1'b0;
        do_read    = 1'b0;
        do_pop     = 1'b0;
        unique case (req_reg.kind) inside
            msb_pkg::KIND_PUSH:
            begin
                if (!in_range)
                begin
                    dec_status = msb_pkg::STATUS_NO_STACK;
                end
                else if (full)
                begin
                    dec_status = msb_pkg::STATUS_OVERFLOW;
                end
                else
                begin
                    do_write = 1'b1;
                end
            end
            msb_pkg::KIND_POP, msb_pkg::KIND_TOP:
            begin
                if (!in_range)
                begin
                    dec_status = msb_pkg::STATUS_NO_STACK;
                end
                else if (empty)
                begin
                    dec_status = msb_pkg::STATUS_UNDERFLOW;
                end
                else
                begin
                    do_read = 1'b1;
                    do_pop  = (req_reg.kind == msb_pkg::KIND_POP);
                end
            end
            default:
            begin
                dec_status = msb_pkg::STATUS_OK;
            end
        endcase
    end

    assign stat.need_read = do_read;

    // Fill counters, all stacks empty after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < USED_STACKS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else if (cmd.execute)
        begin
            if (do_write)
            begin
                fill_reg[idx_sel] <= fill_sel + FILL_W'(1);
            end
            else if (do_pop)
            begin
                fill_reg[idx_sel] <= fill_sel - FILL_W'(1);
            end
        end
    end

    // Stack storage.
    msb_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .en    (cmd.execute && (do_write || do_read)),
        .we    (do_write),
        .addr  (do_write ? push_addr : top_addr),
        .wdata (push_word),
        .rdata (ram_rdata)
    );

    // Request, result and response registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture_req)
        begin
            req_reg <= req_data;
        end
        if (cmd.execute)
        begin
            res_status_reg <= dec_status;
            res_value_reg  <= do_write ? word_wide[msb_pkg::VALUE_W-1:0] : '0;
        end
        else if (cmd.capture_read)
        begin
            res_value_reg <= read_wide[msb_pkg::VALUE_W-1:0];
        end
        if (cmd.load_out)
        begin
            rsp_reg.status       <= res_status_reg;
            rsp_reg.result_value <= res_value_reg;
        end
    end

    assign rsp_data = rsp_reg;

endmodule

`default_nettype wire

/* design/msb_ctrl.sv */
// Controller of the multi-stack bank: sequences one request at a time and
// owns the handshake state of both channels.
// Depends on msb_pkg.
`default_nettype none

module msb_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output msb_pkg::cmd_t       cmd,
    input  wire msb_pkg::stat_t stat
);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_EXEC    = 4'b0010,
        S_FETCH   = 4'b0100,
        S_DELIVER = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture_req = 1'b1;
                    state_next      = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = stat.need_read ? S_FETCH : S_DELIVER;
            end
            S_FETCH:
            begin
                cmd.capture_read = 1'b1;
                state_next       = S_DELIVER;
            end
            S_DELIVER:
            begin
                // The response register is free or its beat leaves now.
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Response valid follows loads and accepted beats.
    always_comb
    begin
        if (cmd.load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

`ifndef ASSERT_OFF
    // A new response never overwrites one that is still held.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(rsp_valid_reg && rsp_stall))
        else $error("response register loaded while a held beat is stalled");

    // An accepted request is executed in the next cycle.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == S_EXEC))
        else $error("accepted request not executed");

    // Execution leads to the read fetch or straight to delivery.
    a_exec_next: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |=> (state_reg == S_FETCH || state_reg == S_DELIVER))
        else $error("bad state after execute");

    // A fetch cycle only follows a request that read the RAM.
    a_fetch_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> $past(stat.need_read))
        else $error("fetch without a RAM read");
`endif

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the multi-stack bank (multi_stack_bank).
// Depends on msb_pkg and the multi_stack_bank RTL; it predicts each response
// from its own mirror of the stack fills and contents and checks it beat by beat.

module tb_top;

    // The request field allows a fourth kind code that the block must treat as a no-op.
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int unsigned STACKS = 16;
    localparam int unsigned DEPTH  = 256;
    localparam int IDX_W = msb_pkg::INDEX_W;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    msb_pkg::req_t req_data = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    msb_pkg::rsp_t rsp_data;
    logic cfg_write_en = 1'b0;
    logic [msb_pkg::CFG_INDEX_W-1:0] cfg_index = msb_pkg::CFG_CAPACITY;
    logic [msb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Stimulus and expectation stores.
    msb_pkg::req_t pending_reqs[$];
    msb_pkg::rsp_t expected_rsps[$];
    msb_pkg::rsp_t want_rsp;

    // Mirror of the block's state and registers.
    logic [8:0] cap_reg = msb_pkg::CAPACITY_RESET;
    logic [4:0] count_reg = msb_pkg::COUNT_RESET;
    int unsigned fill_level [STACKS];
    logic [msb_pkg::VALUE_W-1:0] stack_words [STACKS][DEPTH];

    int unsigned send_idle_pct = 0;
    int unsigned rsp_stall_pct = 0;
    int unsigned phase_no = 0;
    int unsigned mismatch_count = 0;

    multi_stack_bank DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req_data     (req_data),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .rsp_data     (rsp_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // Apply one request to the mirrored stacks and return the response it must produce.
    function automatic msb_pkg::rsp_t predict_stack_op(input msb_pkg::req_t r);
        msb_pkg::rsp_t o;
        int unsigned cap_lim;
        int unsigned cnt_lim;
        int unsigned fill;
        o.status = msb_pkg::STATUS_OK;
        o.result_value = '0;
        cap_lim = (cap_reg > DEPTH) ? DEPTH : cap_reg;
        cnt_lim = (count_reg > STACKS) ? STACKS : count_reg;
        if (r.kind != KIND_SPARE)
        begin
            if (r.stack_index >= cnt_lim)
            begin
                o.status = msb_pkg::STATUS_NO_STACK;
            end
            else
            begin
                fill = fill_level[r.stack_index];
                if (r.kind == msb_pkg::KIND_PUSH)
                begin
                    if (fill >= cap_lim)
                    begin
                        o.status = msb_pkg::STATUS_OVERFLOW;
                    end
                    else
                    begin
                        stack_words[r.stack_index][fill] = r.push_value;
                        fill_level[r.stack_index] = fill + 1;
                        o.result_value = r.push_value;
                    end
                end
                else if (fill == 0)
                begin
                    o.status = msb_pkg::STATUS_UNDERFLOW;
                end
                else
                begin
                    o.result_value = stack_words[r.stack_index][fill - 1];
                    if (r.kind == msb_pkg::KIND_POP)
                    begin
                        fill_level[r.stack_index] = fill - 1;
                    end
                end
            end
        end
        return o;
    endfunction

    // Build a random request; most target stacks in use, a few any index.
    function automatic msb_pkg::req_t random_req(input int unsigned push_pct,
                                                 input int unsigned hi);
        msb_pkg::req_t r;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 3)
        begin
            r.kind = KIND_SPARE;
        end
        else if (pick < 3 + push_pct)
        begin
            r.kind = msb_pkg::KIND_PUSH;
        end
        else
        begin
            r.kind = ($urandom_range(1) == 0) ? msb_pkg::KIND_POP : msb_pkg::KIND_TOP;
        end
        if ($urandom_range(99) < 8)
        begin
            r.stack_index = IDX_W'($urandom_range(STACKS - 1));
        end
        else
        begin
            r.stack_index = IDX_W'($urandom_range(hi, 0));
        end
        case ($urandom_range(7))
            0: r.push_value = 32'h7FFF_FFFF;
            1: r.push_value = 32'h8000_0000;
            2: r.push_value = 32'h0000_0000;
            3: r.push_value = 32'hFFFF_FFFF;
            default: r.push_value = $urandom;
        endcase
        return r;
    endfunction

    task automatic add_req(input logic [1:0] kind, input int unsigned idx,
                           input logic [msb_pkg::VALUE_W-1:0] value);
        msb_pkg::req_t r;
        r.kind = kind;
        r.stack_index = idx[IDX_W-1:0];
        r.push_value = value;
        pending_reqs.push_back(r);
    endtask

    // Write one register at a clock edge and track it in the mirror.
    task automatic write_reg(input logic [msb_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [8:0] value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (idx == msb_pkg::CFG_CAPACITY)
        begin
            cap_reg = value;
        end
        else
        begin
            count_reg = value[4:0];
        end
    endtask

    // Sample at the falling edge so the check never races the driver.
    task automatic wait_drain();
        do
        begin
            @(negedge clk);
        end
        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    // Rotate through the idling patterns, one per phase.
    task automatic next_idling();
        case (phase_no % 4)
            0:
            begin
                send_idle_pct = 0;
                rsp_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct = 57;
                rsp_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                rsp_stall_pct = 57;
            end
            default:
            begin
                send_idle_pct = 36;
                rsp_stall_pct = 36;
            end
        endcase
        phase_no++;
    endtask

    // One setting of both registers, then random requests in two halves with a
    // full drain between them.
    task automatic run_phase(input int unsigned cap, input int unsigned cnt,
                             input int unsigned push_pct, input int unsigned n_items);
        int unsigned k;
        int unsigned hi;
        write_reg(msb_pkg::CFG_CAPACITY, cap[8:0]);
        write_reg(msb_pkg::CFG_COUNT, cnt[8:0]);
        next_idling();
        hi = (cnt == 0) ? 0 : (((cnt > STACKS) ? STACKS : cnt) - 1);
        for (k = 0; k < n_items; k++)
        begin
            if (k == n_items / 2)
            begin
                wait_drain();
            end
            pending_reqs.push_back(random_req(push_pct, hi));
        end
        wait_drain();
    endtask

    // Request driver: holds a beat until it is taken, then maybe loads the next.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                expected_rsps.push_back(predict_stack_op(req_data));
            end
            if (!req_valid || !req_stall)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_data <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: compares each delivered beat with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t: unexpected response: status %0d value %h",
                             $time, rsp_data.status, rsp_data.result_value);
                    mismatch_count++;
                end
                else
                begin
                    want_rsp = expected_rsps.pop_front();
                    if (rsp_data.status !== want_rsp.status)
                    begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want_rsp.status, rsp_data.status);
                        mismatch_count++;
                    end
                    if (rsp_data.result_value !== want_rsp.result_value)
                    begin
                        $display("%0t: result_value mismatch: expected %h, actual %h",
                                 $time, want_rsp.result_value, rsp_data.result_value);
                        mismatch_count++;
                    end
                end
            end
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
        end
    end

    // Main sequence: reset, directed requests, then random phases.
    initial
    begin
        for (int s = 0; s < STACKS; s++)
        begin
            fill_level[s] = 0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: capacity two, stack fifteen out of range.
        write_reg(msb_pkg::CFG_CAPACITY, 9'd2);
        write_reg(msb_pkg::CFG_COUNT, 9'd15);
        next_idling();
        add_req(msb_pkg::KIND_POP, 0, 32'h0);
        add_req(msb_pkg::KIND_TOP, 0, 32'h0);
        add_req(msb_pkg::KIND_PUSH, 0, 32'h7FFF_FFFF);
        add_req(msb_pkg::KIND_PUSH, 0, 32'h8000_0000);
        add_req(msb_pkg::KIND_PUSH, 0, 32'h0000_1234);
        add_req(msb_pkg::KIND_TOP, 0, 32'h0);
        add_req(msb_pkg::KIND_POP, 0, 32'hFFFF_FFFF);
        add_req(msb_pkg::KIND_POP, 0, 32'h0);
        add_req(msb_pkg::KIND_POP, 0, 32'h0);
        add_req(msb_pkg::KIND_PUSH, 14, 32'hFFFF_FFFF);
        add_req(msb_pkg::KIND_PUSH, 14, 32'h0000_0000);
        add_req(msb_pkg::KIND_TOP, 14, 32'h0);
        add_req(msb_pkg::KIND_POP, 14, 32'h0);
        add_req(msb_pkg::KIND_POP, 14, 32'h0);
        add_req(msb_pkg::KIND_PUSH, 15, 32'h0000_0005);
        add_req(msb_pkg::KIND_POP, 15, 32'h0);
        add_req(msb_pkg::KIND_TOP, 15, 32'h0);
        add_req(KIND_SPARE, 15, 32'hFFFF_FFFF);
        add_req(KIND_SPARE, 0, 32'h0);
        add_req(msb_pkg::KIND_PUSH, 3, 32'hAAAA_AAAA);
        add_req(msb_pkg::KIND_PUSH, 3, 32'h5555_5555);
        wait_drain();

        // Random phases over the register extremes and the corner settings.
        run_phase(4, 16, 50, 130);
        run_phase(0, 16, 40, 100);
        run_phase(511, 31, 60, 150);
        run_phase(1, 1, 50, 100);
        run_phase(256, 1, 95, 320);
        run_phase(6, 16, 35, 130);
        run_phase(3, 0, 50, 60);
        run_phase(8, 5, 55, 130);
        run_phase(300, 20, 55, 150);
        run_phase(16, 4, 50, 130);
        run_phase(2, 16, 45, 120);

        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #400000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
